### rtl/core/dqsrch_pkg.sv
// ----------------------------------------------------------------------------
// dqsrch_pkg
// sizes, operation codes and result codes for the deque search unit
// ----------------------------------------------------------------------------
package dqsrch_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int MODE_W = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 3;
    localparam int POS_W  = 4;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam mode_t MODE_APPEND  = 2'd0;
    localparam mode_t MODE_PREPEND = 2'd1;
    localparam mode_t MODE_FIND_FW = 2'd2;
    localparam mode_t MODE_FIND_BW = 2'd3;

    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_FOUND     = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_FULL      = 3'd4;

endpackage

### rtl/core/deque_with_directional_search_unit.sv
// ----------------------------------------------------------------------------
// deque_with_directional_search_unit
// push: item accepted, result registered the next cycle (next item once taken)
// search: one ring-store read per cycle through the single read port of the
//   entry memory, from the chosen end until a hit or the last entry
// reset: front index and entry count cleared at once, entry memory left as is
// ----------------------------------------------------------------------------
module deque_with_directional_search_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dqsrch_pkg::MODE_W-1:0]       mode,
    input  logic signed [dqsrch_pkg::DATA_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dqsrch_pkg::STAT_W-1:0]       status,
    output logic [dqsrch_pkg::POS_W-1:0]        position
);
    import dqsrch_pkg::*;

    // controller states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    localparam logic [PTR_W:0] DEPTH_X = (PTR_W+1)'(DEPTH);
    localparam cnt_t           DEPTH_C = CNT_W'(DEPTH);
    localparam ptr_t           LAST_SLOT = PTR_W'(DEPTH - 1);

    // ring store, one write and one registered read port
    logic [DATA_W-1:0] mem [DEPTH];

    logic              state_reg, state_next;
    ptr_t              front_reg, front_next;
    cnt_t              count_reg, count_next;

    // search context
    logic [DATA_W-1:0] key_reg, key_next;
    logic              back_reg, back_next;
    cnt_t              iter_reg, iter_next;

    // read pipeline: data arrives in the cycle after the address
    logic [DATA_W-1:0] rd_data_reg;
    logic              cmp_vld_reg, cmp_vld_next;
    ptr_t              cmp_pos_reg, cmp_pos_next;
    logic              cmp_last_reg, cmp_last_next;

    // result register
    logic              out_vld_reg, out_vld_next;
    status_t           status_reg, status_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    logic              accept;
    logic              is_push;
    logic              wr_en;
    ptr_t              wr_addr;
    ptr_t              rd_addr;
    ptr_t              scan_pos;
    logic              issue;
    logic              hit;
    logic              done;

    // ring slot of scan_pos, wraps with one compare and subtract
    function automatic ptr_t slot_of(ptr_t front, ptr_t pos);
        logic [PTR_W:0] s;
        s = {1'b0, front} + {1'b0, pos};
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[PTR_W-1:0];
    endfunction

    assign in_ready  = (state_reg == S_IDLE) && (!out_vld_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign is_push   = (mode == MODE_APPEND) || (mode == MODE_PREPEND);
    assign out_valid = out_vld_reg;
    assign status    = status_reg;
    assign position  = pos_reg;

    // position being read this cycle, counted from the front
    assign scan_pos = back_reg ? PTR_W'(count_reg - cnt_t'(1) - iter_reg)
                               : PTR_W'(iter_reg);
    assign rd_addr  = slot_of(front_reg, scan_pos);

    assign hit  = cmp_vld_reg && (rd_data_reg == key_reg);
    assign done = cmp_vld_reg && (hit || cmp_last_reg);
    assign issue = (state_reg == S_SCAN) && !done && (iter_reg < count_reg);

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        back_next     = back_reg;
        iter_next     = iter_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        status_next   = status_reg;
        pos_next      = pos_reg;
        wr_en         = 1'b0;
        wr_addr       = slot_of(front_reg, PTR_W'(count_reg));
        cmp_vld_next  = issue;
        cmp_pos_next  = scan_pos;
        cmp_last_next = (iter_reg == count_reg - cnt_t'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_vld_next = 1'b1;
                    pos_next     = '0;
                    if (is_push)
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + cnt_t'(1);
                            status_next = ST_INSERTED;
                            if (mode == MODE_PREPEND)
                            begin
                                // front steps back one slot, new item lands there
                                front_next = (front_reg == '0) ? LAST_SLOT
                                                               : front_reg - ptr_t'(1);
                                wr_addr    = front_next;
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        // search: hold the result until the scan ends
                        out_vld_next = 1'b0;
                        key_next     = value;
                        back_next    = (mode == MODE_FIND_BW);
                        iter_next    = '0;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    iter_next = iter_reg + cnt_t'(1);
                end
                if (done)
                begin
                    out_vld_next = 1'b1;
                    status_next  = hit ? ST_FOUND : ST_NOT_FOUND;
                    pos_next     = hit ? POS_W'(cmp_pos_reg) : '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        back_reg     <= back_next;
        cmp_pos_reg  <= cmp_pos_next;
        cmp_last_reg <= cmp_last_next;
        status_reg   <= status_next;
        pos_reg      <= pos_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            iter_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            iter_reg    <= iter_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

### tb/deque_with_directional_search_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_directional_search_unit_tb
// a short table of directed operations, then random pushes and searches under
// four pacing phases; every result is checked, typed rows against their own
// expectation and the rest against a cycle-free copy of the deque in the bench
// ----------------------------------------------------------------------------
module deque_with_directional_search_unit_tb;

    import dqsrch_pkg::*;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        mode_t           op;
        logic [DATA_W-1:0] arg;
        logic            typed;
        status_t         st;
        logic [POS_W-1:0] pos;
    } plan_row_t;

    typedef struct packed {
        status_t          st;
        logic [POS_W-1:0] pos;
    } outcome_t;

    localparam int PLAN_LEN   = 26;
    localparam int PHASE_LEN  = 132;
    localparam int HOLD_LEN   = 300;
    localparam int TAIL_LEN   = 4 * DEPTH;
    localparam int MAX_PRINTS = 40;

    // empty searches, extremes of the value, simple hits and misses, then
    // duplicates, a fill across the ring wrap and pushes onto a full store
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{MODE_FIND_FW,  32'h0000_0000, 1'b1, ST_EMPTY,     4'd0},
        '{MODE_FIND_BW,  32'h8000_0000, 1'b1, ST_EMPTY,     4'd0},
        '{MODE_APPEND,   32'h7FFF_FFFF, 1'b1, ST_INSERTED,  4'd0},
        '{MODE_PREPEND,  32'h8000_0000, 1'b1, ST_INSERTED,  4'd0},
        '{MODE_FIND_FW,  32'h7FFF_FFFF, 1'b1, ST_FOUND,     4'd1},
        '{MODE_FIND_BW,  32'h8000_0000, 1'b1, ST_FOUND,     4'd0},
        '{MODE_FIND_FW,  32'h0000_0000, 1'b1, ST_NOT_FOUND, 4'd0},
        '{MODE_APPEND,   32'h0000_0005, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_PREPEND,  32'h0000_0005, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_FIND_FW,  32'h0000_0005, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_FIND_BW,  32'h0000_0005, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_APPEND,   32'hFFFF_FFFF, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_PREPEND,  32'h0000_0000, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_APPEND,   32'h0000_0001, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_PREPEND,  32'h5555_5555, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_APPEND,   32'hAAAA_AAAA, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_PREPEND,  32'h7FFF_FFFF, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_APPEND,   32'h8000_0001, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_PREPEND,  32'hFFFF_FFFE, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_APPEND,   32'h0F0F_0F0F, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_PREPEND,  32'h0000_0005, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_APPEND,   32'hC000_0000, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_PREPEND,  32'h3FFF_FFFF, 1'b0, ST_INSERTED,  4'd0},
        '{MODE_APPEND,   32'h0000_0123, 1'b1, ST_FULL,      4'd0},
        '{MODE_PREPEND,  32'hFFFF_FFF9, 1'b1, ST_FULL,      4'd0},
        '{MODE_FIND_BW,  32'hC000_0000, 1'b0, ST_INSERTED,  4'd0}
    };

    // dut connections
    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         position;

    // bench copy of the deque, advanced once per accepted item
    logic [DATA_W-1:0] ring_copy [DEPTH];
    ptr_t              head_copy;
    cnt_t              count_copy;

    outcome_t due_outcomes [$];

    // pacing knobs, read by the sender and receiver processes
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int n_mismatch;

    deque_with_directional_search_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .position  (position)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: applies one operation to the bench copy, returns its outcome
    // ------------------------------------------------------------------------
    function automatic outcome_t predict_outcome(mode_t op, logic [DATA_W-1:0] key);
        outcome_t o;
        int       p;
        bit       hit;
        o.st = ST_INSERTED;
        o.pos = '0;
        hit = 1'b0;
        if (op == MODE_APPEND || op == MODE_PREPEND)
        begin
            // a full store drops the push and leaves everything untouched
            if (int'(count_copy) >= DEPTH)
                o.st = ST_FULL;
            else
            begin
                if (op == MODE_APPEND)
                    ring_copy[(int'(head_copy) + int'(count_copy)) % DEPTH] = key;
                else
                begin
                    head_copy = ptr_t'((int'(head_copy) + DEPTH - 1) % DEPTH);
                    ring_copy[head_copy] = key;
                end
                count_copy = count_copy + 1'b1;
            end
        end
        else if (count_copy == '0)
            o.st = ST_EMPTY;
        else
        begin
            // scan from the chosen end, nearest duplicate wins
            o.st = ST_NOT_FOUND;
            for (int i = 0; i < int'(count_copy) && !hit; i++)
            begin
                p = (op == MODE_FIND_FW) ? i : int'(count_copy) - 1 - i;
                if (ring_copy[(int'(head_copy) + p) % DEPTH] == key)
                begin
                    hit = 1'b1;
                    o.st = ST_FOUND;
                    o.pos = p[POS_W-1:0];
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        if (n_mismatch < MAX_PRINTS)
            $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
        n_mismatch++;
    endtask

    // ------------------------------------------------------------------------
    // sender: optional idle gap, then hold the item until it is accepted
    // ------------------------------------------------------------------------
    task automatic offer_item(mode_t op, logic [DATA_W-1:0] arg, logic typed,
                              status_t t_st, logic [POS_W-1:0] t_pos);
        outcome_t o;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = op;
        value    = arg;
        do
            @(posedge clk);
        while (!in_ready);
        // accepted at this edge: advance the copy and queue the outcome
        o = predict_outcome(op, arg);
        if (typed)
        begin
            o.st  = t_st;
            o.pos = t_pos;
        end
        due_outcomes.push_back(o);
    endtask

    // mostly searches for keys that are stored, some near misses and noise;
    // pushes onto the full store are mixed in
    task automatic offer_random_item();
        mode_t            op;
        logic [DATA_W-1:0] arg;
        int               r;
        int               k;
        int               idx;
        r = $urandom_range(99);
        k = $urandom_range(9);
        idx = 0;
        if (count_copy != '0)
            idx = (int'(head_copy) + int'($urandom_range(int'(count_copy) - 1))) % DEPTH;
        if (r < 15)
        begin
            op  = ($urandom_range(1) == 0) ? MODE_APPEND : MODE_PREPEND;
            arg = $urandom;
        end
        else
        begin
            op = ($urandom_range(1) == 0) ? MODE_FIND_FW : MODE_FIND_BW;
            if (count_copy != '0 && k < 6)
                arg = ring_copy[idx];
            else if (count_copy != '0 && k < 8)
                arg = ring_copy[idx] ^ (32'h1 << $urandom_range(DATA_W - 1));
            else
                arg = $urandom;
        end
        offer_item(op, arg, 1'b0, ST_INSERTED, '0);
    endtask

    // sender drops valid and stands back until every outcome has been seen
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (due_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: random back-pressure plus one long counted hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        outcome_t o;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (due_outcomes.size() == 0)
                    report_mismatch("result with nothing outstanding, status",
                                    DATA_W'(status), '0);
                else
                begin
                    o = due_outcomes.pop_front();
                    if (status !== o.st)
                        report_mismatch("status", DATA_W'(status), DATA_W'(o.st));
                    if (position !== o.pos)
                        report_mismatch("position", DATA_W'(position), DATA_W'(o.pos));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // initialise inputs and the bench copy, hold reset, then release it
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_APPEND;
        value          = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        n_mismatch     = 0;
        head_copy      = '0;
        count_copy     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, no idling
        for (int n = 0; n < PLAN_LEN; n++)
            offer_item(PLAN[n].op, PLAN[n].arg, PLAN[n].typed, PLAN[n].st, PLAN[n].pos);
        wait_drained();

        // random phases: no idling with a long hold at the start, sender
        // idle, receiver stalling, then both idling lightly
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_left = HOLD_LEN; end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            repeat (PHASE_LEN) offer_random_item();
            wait_drained();
        end

        @(negedge clk);
        in_valid = 1'b0;
        wait_drained();
        // allow a stray late result to show up before judging
        repeat (TAIL_LEN) @(posedge clk);
        if (n_mismatch == 0)
            $display("[deque_with_directional_search_unit] OK");
        else
            $display("[deque_with_directional_search_unit] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("[deque_with_directional_search_unit] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/dqsrch_pkg.sv
rtl/core/deque_with_directional_search_unit.sv
tb/deque_with_directional_search_unit_tb.sv
